// ===== rtl/first_fit_block_allocator_core_assert.svh =====
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// Shared types, constants and codes of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  // Fixed field widths of the item and result ports.
  localparam int SIZE_W   = 24;
  localparam int HANDLE_W = 6;
  localparam int BREAK_W  = 25;
  localparam int ADDR_W   = 25;
  localparam int STATUS_W = 2;

  // Parameter defaults and register reset value.
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 32;
  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST = 24'd65536;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOMEM = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BADH  = 2'd3;

  // Request action codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Datapath operation codes issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_SCAN_START = 4'd2;
  localparam logic [OP_W-1:0] OP_SCAN_STEP  = 4'd3;
  localparam logic [OP_W-1:0] OP_FREE_RD    = 4'd4;
  localparam logic [OP_W-1:0] OP_REUSE      = 4'd5;
  localparam logic [OP_W-1:0] OP_APPEND     = 4'd6;
  localparam logic [OP_W-1:0] OP_RELEASE    = 4'd7;
  localparam logic [OP_W-1:0] OP_MARK       = 4'd8;
  localparam logic [OP_W-1:0] OP_RSP_ZERO   = 4'd9;
  localparam logic [OP_W-1:0] OP_RSP_NOMEM  = 4'd10;
  localparam logic [OP_W-1:0] OP_RSP_BADH   = 4'd11;

  // One word of the block table.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] base;
  } blk_entry_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
  } ffba_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic req_zero;
    logic handle_bad;
    logic handle_last;
    logic hit;
    logic scan_done;
    logic append_ok;
  } ffba_flags_t;

endpackage

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
`timescale 1ns / 1ps

module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ffba_flags_t flags,
  output ffba_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DECODE  = 2'd1;
  localparam logic [1:0] S_SCAN    = 2'd2;
  localparam logic [1:0] S_FREE_WR = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and the one datapath operation of this cycle.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags.is_alloc) begin
          if (flags.req_zero) begin
            cmd.op    = OP_RSP_ZERO;
            state_nxt = S_IDLE;
          end else begin
            cmd.op    = OP_SCAN_START;
            state_nxt = S_SCAN;
          end
        end else if (flags.handle_bad) begin
          cmd.op    = OP_RSP_BADH;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_FREE_RD;
          state_nxt = S_FREE_WR;
        end
      end
      S_SCAN: begin
        priority if (flags.hit) begin
          cmd.op    = OP_REUSE;
          state_nxt = S_IDLE;
        end else if (flags.scan_done) begin
          cmd.op    = flags.append_ok ? OP_APPEND : OP_RSP_NOMEM;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_FREE_WR: begin
        cmd.op    = flags.handle_last ? OP_RELEASE : OP_MARK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ffba_datapath.sv =====
// Datapath of the first-fit block allocator: block table, heap state and result registers.
`timescale 1ns / 1ps

module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_cmd_t           cmd,
  output ffba_flags_t         flags,
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  input  logic                in_action,
  input  logic [SIZE_W-1:0]   in_req_size,
  input  logic [HANDLE_W-1:0] in_block_handle,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_granted_handle,
  output logic [ADDR_W-1:0]   out_payload_addr,
  output logic                out_reused,
  output logic                out_released
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
  localparam int NEED_W = BREAK_W + 1;

  // Block table and its registered read port.
  blk_entry_t mem [MAX_BLOCKS];
  blk_entry_t rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  blk_entry_t       wr_data;

  // Heap state and configuration.
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [BREAK_W-1:0] break_r;
  logic [BREAK_W-1:0] break_nxt;
  logic [SIZE_W-1:0]  limit_r;

  // Latched request.
  logic                action_r;
  logic [SIZE_W-1:0]   req_size_r;
  logic [HANDLE_W-1:0] handle_r;

  // Scan pointers.
  logic [CNT_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_vld_r;

  logic [CMP_W-1:0]   handle_cmp;
  logic [CMP_W-1:0]   count_cmp;
  logic [IDX_W-1:0]   handle_idx;
  logic [NEED_W-1:0]  need;
  logic               rsp_en;

  assign handle_cmp = CMP_W'(handle_r);
  assign count_cmp  = CMP_W'(count_r);
  assign handle_idx = IDX_W'(handle_cmp);
  assign need       = NEED_W'(break_r) + NEED_W'(HEADER_BYTES) + NEED_W'(req_size_r);

  // Status flags for the controller.
  assign flags.is_alloc    = (action_r == ACT_ALLOC);
  assign flags.req_zero    = (req_size_r == '0);
  assign flags.handle_bad  = (handle_cmp >= count_cmp);
  assign flags.handle_last = ((CMP_W + 1)'(handle_cmp) + (CMP_W + 1)'(1))
                             == (CMP_W + 1)'(count_cmp);
  assign flags.hit         = chk_vld_r && rd_data_r.free && (rd_data_r.size >= req_size_r);
  assign flags.scan_done   = !chk_vld_r && (rd_idx_r == count_r);
  assign flags.append_ok   = (count_r != CNT_W'(MAX_BLOCKS)) &&
                             (need <= NEED_W'(limit_r));

  // Table port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = handle_idx;
    wr_en   = 1'b0;
    wr_addr = handle_idx;
    wr_data = rd_data_r;
    unique case (cmd.op)
      OP_SCAN_STEP: begin
        rd_en   = (rd_idx_r != count_r);
        rd_addr = rd_idx_r[IDX_W-1:0];
      end
      OP_FREE_RD: begin
        rd_en = 1'b1;
      end
      OP_REUSE: begin
        wr_en        = 1'b1;
        wr_addr      = chk_idx_r;
        wr_data.free = 1'b0;
      end
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count_r[IDX_W-1:0];
        wr_data = '{free: 1'b0, size: req_size_r, base: break_r[SIZE_W-1:0]};
      end
      OP_MARK: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Next block count and heap break.
  always_comb begin
    count_nxt = count_r;
    break_nxt = break_r;
    if (cmd.op == OP_APPEND) begin
      count_nxt = count_r + CNT_W'(1);
      break_nxt = BREAK_W'(need);
    end else if (cmd.op == OP_RELEASE) begin
      count_nxt = CNT_W'(handle_idx);
      break_nxt = BREAK_W'(rd_data_r.base);
    end
  end

  // Control registers: heap state, limit and scan valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      break_r   <= '0;
      limit_r   <= HEAP_LIMIT_RST;
      chk_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count_r <= count_nxt;
      break_r <= break_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.op == OP_SCAN_START) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.op == OP_SCAN_STEP) begin
        chk_vld_r <= (rd_idx_r != count_r);
      end
      out_valid <= rsp_en;
    end
  end

  // Request latch and scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      action_r   <= in_action;
      req_size_r <= in_req_size;
      handle_r   <= in_block_handle;
    end
    if (cmd.op == OP_SCAN_START) begin
      rd_idx_r <= '0;
    end else if (cmd.op == OP_SCAN_STEP && rd_idx_r != count_r) begin
      rd_idx_r  <= rd_idx_r + CNT_W'(1);
      chk_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  assign rsp_en = (cmd.op == OP_REUSE) || (cmd.op == OP_APPEND) || (cmd.op == OP_RELEASE) ||
                  (cmd.op == OP_MARK) || (cmd.op == OP_RSP_ZERO) ||
                  (cmd.op == OP_RSP_NOMEM) || (cmd.op == OP_RSP_BADH);

  // Result registers; fields without meaning are zero.
  always_ff @(posedge clk) begin
    if (rsp_en) begin
      out_status         <= STS_OK;
      out_granted_handle <= '0;
      out_payload_addr   <= '0;
      out_reused         <= 1'b0;
      out_released       <= 1'b0;
      unique case (cmd.op)
        OP_REUSE: begin
          out_granted_handle <= HANDLE_W'(chk_idx_r);
          out_payload_addr   <= ADDR_W'(rd_data_r.base) + ADDR_W'(HEADER_BYTES);
          out_reused         <= 1'b1;
        end
        OP_APPEND: begin
          out_granted_handle <= HANDLE_W'(count_r);
          out_payload_addr   <= ADDR_W'(break_r[SIZE_W-1:0]) + ADDR_W'(HEADER_BYTES);
        end
        OP_RELEASE: begin
          out_released <= 1'b1;
        end
        OP_RSP_ZERO: begin
          out_status <= STS_ZERO;
        end
        OP_RSP_NOMEM: begin
          out_status <= STS_NOMEM;
        end
        OP_RSP_BADH: begin
          out_status <= STS_BADH;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator: controller, datapath and checks.
//
//   Channel  Direction  Handshake           Payload
//   in_      into core  start / busy        in_action, in_req_size, in_block_handle
//   out_     from core  out_valid strobe    out_status, out_granted_handle,
//                                           out_payload_addr, out_reused, out_released
//   cfg_     into core  cfg_we              cfg_wdata (heap limit)
//
// A zero-size allocate and a bad handle are answered from the decode state, and a
// valid free from the free-write state after its table read. An allocate scans the
// block table one entry per cycle through the table's single read port: a hit is
// answered once its entry's read data is checked, and an append or an out-of-memory
// answer comes after the scan has passed the last entry. busy is low on the cycle
// the result strobe is high, so the next item may be accepted then.
// Reset is synchronous and empties the table at once; no clearing pass is needed.
// Results are never stalled.
`timescale 1ns / 1ps

module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [SIZE_W-1:0]   in_req_size,
  input  logic [HANDLE_W-1:0] in_block_handle,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_granted_handle,
  output logic [ADDR_W-1:0]   out_payload_addr,
  output logic                out_reused,
  output logic                out_released,
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata
);

`include "first_fit_block_allocator_core_assert.svh"

  ffba_cmd_t   cmd;
  ffba_flags_t flags;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .flags              (flags),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_req_size        (in_req_size),
    .in_block_handle    (in_block_handle),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_payload_addr   (out_payload_addr),
    .out_reused         (out_reused),
    .out_released       (out_released)
  );

  // An accepted item keeps the core busy in the following cycle.
  `FFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not make core busy")

  // A result is strobed only once the controller is back in idle.
  `FFBA_ASSERT_ALWAYS(a_rsp_idle, !out_valid || !busy, "result strobed while core busy")

  // The cycle that accepts an item issues no result, so strobes never come back to back.
  `FFBA_ASSERT_NEXT(a_rsp_single, out_valid, !out_valid, "two result strobes in a row")

  // A reuse and a release never appear in the same result.
  `FFBA_ASSERT_ALWAYS(a_rsp_flags, !out_valid || !(out_reused && out_released),
                      "result marked both reused and released")

endmodule
